/* hw/rtl/modexp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_pkg: shared types and constants for the modular exponentiation block
// Holds the request and result structs, the pass tags and the sequencer states.
// ----------------------------------------------------------------------------
package modexp_pkg;

  // Width of every data field on the ports.
  localparam int unsigned DataBits    = 32;
  // Default parameter values.
  localparam int unsigned ModBitsDef  = 32;
  localparam int unsigned ExpBitsDef  = 32;

  typedef struct packed {
    logic [DataBits-1:0] base_value;
    logic [DataBits-1:0] exponent;
  } in_t;

  typedef struct packed {
    logic [DataBits-1:0] power_result;
    logic                modulus_error;
  } out_t;

  // Tag of a product travelling down the cell row.
  typedef enum logic {
    TAG_ACC = 1'b0,
    TAG_SQR = 1'b1
  } tag_e;

  // Valid and tag of one slot of the cell row.
  typedef struct packed {
    logic valid;
    tag_e tag;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_WRED,
    S_MA,
    S_MS,
    S_WMUL,
    S_FIN
  } state_e;

endpackage

/* hw/rtl/modexp_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_cell: one step of interleaved modular multiplication
// Takes the top multiplier bit, doubles the partial result, adds the
// multiplicand when the bit is set and reduces below the modulus.
// ----------------------------------------------------------------------------
module modexp_cell #(
  parameter int unsigned MOD_BITS = modexp_pkg::ModBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [MOD_BITS-1:0]                mod_i,
  input  modexp_pkg::slot_t                  slot_i,
  input  logic [MOD_BITS-1:0]                r_i,
  input  logic [MOD_BITS-1:0]                a_i,
  input  logic [modexp_pkg::DataBits-1:0]    mul_i,
  output modexp_pkg::slot_t                  slot_o,
  output logic [MOD_BITS-1:0]                r_o,
  output logic [MOD_BITS-1:0]                a_o,
  output logic [modexp_pkg::DataBits-1:0]    mul_o
);

  localparam int unsigned DB = modexp_pkg::DataBits;

  logic [MOD_BITS+1:0] sum;
  logic [MOD_BITS+1:0] m1;
  logic [MOD_BITS+1:0] m2;
  logic [MOD_BITS-1:0] r_d;

  modexp_pkg::slot_t          slot_q;
  logic [MOD_BITS-1:0]        r_q;
  logic [MOD_BITS-1:0]        a_q;
  logic [DB-1:0]              mul_q;

  // Double, add and bring back below the modulus (sum stays under 3m).
  always_comb begin
    m1  = {2'b00, mod_i};
    m2  = {1'b0, mod_i, 1'b0};
    sum = {1'b0, r_i, 1'b0} + (mul_i[DB-1] ? {2'b00, a_i} : '0);
    if (sum >= m2) begin
      r_d = MOD_BITS'(sum - m2);
    end else if (sum >= m1) begin
      r_d = MOD_BITS'(sum - m1);
    end else begin
      r_d = sum[MOD_BITS-1:0];
    end
  end

  // Slot control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_i;
    end
  end

  // Data handed to the next cell.
  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    a_q   <= a_i;
    mul_q <= {mul_i[DB-2:0], 1'b0};
  end

  assign slot_o = slot_q;
  assign r_o    = r_q;
  assign a_o    = a_q;
  assign mul_o  = mul_q;

endmodule

/* hw/rtl/modexp_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modexp_row: row of multiplication cells
// One cell per multiplier bit; a new product may enter the row in every cycle.
// ----------------------------------------------------------------------------
module modexp_row #(
  parameter int unsigned MOD_BITS = modexp_pkg::ModBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [MOD_BITS-1:0]             mod_i,
  input  modexp_pkg::slot_t               slot_i,
  input  logic [MOD_BITS-1:0]             a_i,
  input  logic [modexp_pkg::DataBits-1:0] mul_i,
  output modexp_pkg::slot_t               slot_o,
  output logic [MOD_BITS-1:0]             r_o
);

  localparam int unsigned N = modexp_pkg::DataBits;

  modexp_pkg::slot_t          slot_w [N+1];
  logic [MOD_BITS-1:0]        r_w    [N+1];
  logic [MOD_BITS-1:0]        a_w    [N+1];
  logic [N-1:0]               mul_w  [N+1];

  assign slot_w[0] = slot_i;
  assign r_w[0]    = '0;
  assign a_w[0]    = a_i;
  assign mul_w[0]  = mul_i;

  // Chain the cells.
  for (genvar k = 0; k < N; k++) begin : g_cell
    modexp_cell #(.MOD_BITS(MOD_BITS)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .mod_i  (mod_i),
      .slot_i (slot_w[k]),
      .r_i    (r_w[k]),
      .a_i    (a_w[k]),
      .mul_i  (mul_w[k]),
      .slot_o (slot_w[k+1]),
      .r_o    (r_w[k+1]),
      .a_o    (a_w[k+1]),
      .mul_o  (mul_w[k+1])
    );
  end

  assign slot_o = slot_w[N];
  assign r_o    = r_w[N];

endmodule

/* hw/rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation: base^exponent mod modulus
// Right-to-left square-and-multiply over a row of interleaved multiply cells.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid / stall    | base_value, exponent
// out     | output    | out_valid / stall   | power_result, modulus_error
// cfg     | input     | cfg_valid / ready   | modulus
//
// The base is first reduced in one pass through the 32-cell row. Each
// exponent bit up to the highest set one then makes a pass in which the
// multiply and the square enter the row back to back. A zero exponent or a
// zero modulus skips the row and goes straight to the final state.
// No new request is taken until the result is in the
// output register; a stalled result holds the block in its final state.
// Reset clears the modulus to zero and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
  parameter int unsigned MOD_BITS = modexp_pkg::ModBitsDef,
  parameter int unsigned EXP_BITS = modexp_pkg::ExpBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  modexp_pkg::in_t                 in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output modexp_pkg::out_t                out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [modexp_pkg::DataBits-1:0] cfg_data_i
);

  localparam int unsigned DB = modexp_pkg::DataBits;
  localparam int unsigned EW = (EXP_BITS < DB) ? EXP_BITS : DB;

  logic [DB-1:0]             modulus_q;
  logic [MOD_BITS-1:0]       mod_w;
  modexp_pkg::state_e        state_q, state_d;
  logic [MOD_BITS-1:0]       acc_q, acc_d;
  logic [MOD_BITS-1:0]       b_q, b_d;
  logic [DB-1:0]             raw_q, raw_d;
  logic [EW-1:0]             e_q, e_d;
  logic                      err_q, err_d;
  logic                      out_valid_q, out_valid_d;
  modexp_pkg::out_t          out_q, out_d;
  modexp_pkg::slot_t         inj_slot, ret_slot;
  logic [MOD_BITS-1:0]       inj_a, ret_r;
  logic [DB-1:0]             inj_mul;
  logic                      accept;
  logic                      out_free;

  assign mod_w       = modulus_q[MOD_BITS-1:0];
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != modexp_pkg::S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Modulus register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= '0;
    end else if (cfg_valid_i) begin
      modulus_q <= cfg_data_i;
    end
  end

  modexp_row #(.MOD_BITS(MOD_BITS)) u_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_w),
    .slot_i (inj_slot),
    .a_i    (inj_a),
    .mul_i  (inj_mul),
    .slot_o (ret_slot),
    .r_o    (ret_r)
  );

  // Sequencer: next state, operand injection and result capture.
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    b_d         = b_q;
    raw_d       = raw_q;
    e_d         = e_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    inj_slot    = '0;
    inj_a       = '0;
    inj_mul     = '0;
    unique case (state_q)
      modexp_pkg::S_IDLE: begin
        if (accept) begin
          raw_d = in_data_i.base_value;
          e_d   = in_data_i.exponent[EW-1:0];
          acc_d = MOD_BITS'(1);
          err_d = 1'b0;
          if (mod_w == '0) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = modexp_pkg::S_FIN;
          end else if (in_data_i.exponent[EW-1:0] == '0) begin
            state_d = modexp_pkg::S_FIN;
          end else begin
            state_d = modexp_pkg::S_RED;
          end
        end
      end
      modexp_pkg::S_RED: begin
        // Reduce the base: 1 times base, modulo m.
        inj_slot = '{valid: 1'b1, tag: modexp_pkg::TAG_SQR};
        inj_a    = MOD_BITS'(1);
        inj_mul  = raw_q;
        state_d  = modexp_pkg::S_WRED;
      end
      modexp_pkg::S_WRED: begin
        if (ret_slot.valid) begin
          b_d     = ret_r;
          state_d = modexp_pkg::S_MA;
        end
      end
      modexp_pkg::S_MA: begin
        inj_slot = '{valid: 1'b1, tag: modexp_pkg::TAG_ACC};
        inj_a    = acc_q;
        inj_mul  = DB'(b_q);
        state_d  = modexp_pkg::S_MS;
      end
      modexp_pkg::S_MS: begin
        inj_slot = '{valid: 1'b1, tag: modexp_pkg::TAG_SQR};
        inj_a    = b_q;
        inj_mul  = DB'(b_q);
        state_d  = modexp_pkg::S_WMUL;
      end
      modexp_pkg::S_WMUL: begin
        if (ret_slot.valid) begin
          if (ret_slot.tag == modexp_pkg::TAG_ACC) begin
            if (e_q[0]) begin
              acc_d = ret_r;
            end
          end else begin
            b_d = ret_r;
            e_d = e_q >> 1;
            if ((e_q >> 1) == '0) begin
              state_d = modexp_pkg::S_FIN;
            end else begin
              state_d = modexp_pkg::S_MA;
            end
          end
        end
      end
      modexp_pkg::S_FIN: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.power_result  = DB'(acc_q);
          out_d.modulus_error = err_q;
          state_d             = modexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = modexp_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= modexp_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    b_q   <= b_d;
    raw_q <= raw_d;
    e_q   <= e_d;
    err_q <= err_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // Products return from the row only while the sequencer waits for them.
  a_ret_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_slot.valid |-> (state_q == modexp_pkg::S_WRED || state_q == modexp_pkg::S_WMUL))
    else $error("product left the cell row outside a wait state");

  // An error result always carries a zero value.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.modulus_error) |-> (out_q.power_result == '0))
    else $error("modulus error with nonzero result");

  // A finished result waits while the output register is still held.
  a_fin_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == modexp_pkg::S_FIN && out_valid_q && out_stall_i)
      |=> (state_q == modexp_pkg::S_FIN))
    else $error("result left final state over a stalled output");

  // Results never exceed the modulus width.
  a_res_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.power_result >> MOD_BITS) == '0))
    else $error("result wider than the modulus");
`endif

endmodule

/* dv/modular_exponentiation_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_test: self-checking bench for the modexp block
// Sends base/exponent requests under several moduli, predicts each result
// with a local square-and-multiply model and checks every returned result in
// order. Both channels see random idle bursts except in the final phase.
// ----------------------------------------------------------------------------
module modular_exponentiation_test;

  localparam int unsigned CycleLimit = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  modexp_pkg::in_t  in_data;
  logic out_valid;
  logic out_stall;
  modexp_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [modexp_pkg::DataBits-1:0] cfg_data;

  // Local copy of the modulus register and the queue of predicted results.
  logic [modexp_pkg::DataBits-1:0] modulus_copy;
  modexp_pkg::out_t  pending_results[$];
  int    mismatch_count;
  int    cycle_count;
  bit    idle_enable;

  modular_exponentiation i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle counter with timeout.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Square-and-multiply prediction of one result under the current modulus.
  function automatic modexp_pkg::out_t predict_power(logic [31:0] b, logic [31:0] e);
    modexp_pkg::out_t r;
    logic [63:0] acc;
    logic [63:0] run;
    logic [63:0] m;
    m = {32'd0, modulus_copy};
    r.power_result = '0;
    r.modulus_error = 1'b0;
    if (m == 0) begin
      r.modulus_error = 1'b1;
    end else if (e == 0) begin
      r.power_result = 32'd1;
    end else begin
      acc = 64'd1;
      run = {32'd0, b} % m;
      for (int i = 0; i < 32; i++) begin
        if (e[i]) acc = (acc * run) % m;
        run = (run * run) % m;
      end
      r.power_result = acc[31:0];
    end
    return r;
  endfunction

  // Send one request, with an optional idle burst before it.
  task automatic send_request(logic [31:0] b, logic [31:0] e);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{base_value: b, exponent: e};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_power(b, e));
    in_valid <= 1'b0;
    // The block stalls right after an accepted request, so this edge is free.
    @(posedge clk);
  endtask

  // Write the modulus once all results are back and the block is idle.
  task automatic write_modulus(logic [31:0] value);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    modulus_copy = value;
  endtask

  // Output stall generator: random bursts while idling is enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result %h", out_data);
      end else begin
        modexp_pkg::out_t want;
        want = pending_results.pop_front();
        if (want.power_result !== out_data.power_result ||
            want.modulus_error !== out_data.modulus_error) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Mismatch: expected result %h error %b, got result %h error %b",
                     want.power_result, want.modulus_error,
                     out_data.power_result, out_data.modulus_error);
          end
        end
      end
    end
  end

  // Zero modulus right after reset: every request must flag the error.
  task automatic test_zero_modulus();
    send_request(32'd5, 32'd3);
    send_request(32'hFFFF_FFFF, 32'd0);
  endtask

  // Field extremes and zero exponent, including a modulus of one.
  task automatic test_directed();
    write_modulus(32'd1);
    send_request(32'd7, 32'd0);
    send_request(32'd7, 32'd5);
    write_modulus(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_request(32'd0, 32'd1);
    send_request(32'd0, 32'd0);
    send_request(32'd2, 32'h8000_0000);
    send_request(32'h1234_5678, 32'd1);
    write_modulus(32'd3233);
    send_request(32'd65, 32'd17);
    send_request(32'd2790, 32'd2753);
    send_request(32'd3233, 32'd9);
    write_modulus(32'd2);
    send_request(32'd3, 32'd7);
    write_modulus(32'h8000_0000);
    send_request(32'hDEAD_BEEF, 32'hAAAA_5555);
  endtask

  // Random requests under a few random moduli, full-width exponents for half.
  task automatic test_random(int count);
    logic [31:0] e;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 3))
          0: write_modulus($urandom_range(2, 255));
          1: write_modulus($urandom());
          2: write_modulus(32'd0);
          default: write_modulus(32'hFFFF_FFFF - $urandom_range(0, 15));
        endcase
      end
      case ($urandom_range(0, 3))
        0: e = $urandom_range(0, 31);
        1: e = $urandom() >> $urandom_range(0, 31);
        default: e = $urandom();
      endcase
      send_request($urandom(), e);
    end
  endtask

  // Main sequence.
  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    modulus_copy   = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_enable    = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_modulus();
    test_directed();
    test_random(220);
    idle_enable = 1'b0;
    test_random(45);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* modular_exponentiation.f */
hw/rtl/modexp_pkg.sv
hw/rtl/modexp_cell.sv
hw/rtl/modexp_row.sv
hw/rtl/modular_exponentiation.sv
dv/modular_exponentiation_test.sv
